@@ rtl/japc_pkg.sv @@
// shared types, codes and widths for the joystick axis position conditioner
package japc_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int OFFSET_W    = 12;
    localparam int POSITION_W  = 8;
    localparam int EVENT_W     = 2;
    localparam int OP_W        = 2;
    localparam int VAL_W       = 14;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 12;

    localparam int DEF_SAMPLES_PER_AVERAGE = 2;
    localparam int DEF_POSITION_SPAN       = 200;
    localparam int DEF_ADC_FULL_SCALE      = (1 << SAMPLE_W) - 1;

    localparam logic [OP_W-1:0] OP_X      = 2'd0;
    localparam logic [OP_W-1:0] OP_Y      = 2'd1;
    localparam logic [OP_W-1:0] OP_BUTTON = 2'd2;

    localparam logic [EVENT_W-1:0] EVT_NONE    = 2'd0;
    localparam logic [EVENT_W-1:0] EVT_PRESS   = 2'd1;
    localparam logic [EVENT_W-1:0] EVT_RELEASE = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_TRIM_X = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIM_Y = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [SAMPLE_W-1:0] sample;
        logic                button_level;
    } in_item_t;

    typedef struct packed {
        logic signed [POSITION_W-1:0] position;
        logic                         updated;
        logic [EVENT_W-1:0]           button_event;
    } out_item_t;

endpackage

@@ rtl/joystick_axis_position_conditioner.sv @@
// joystick axis position conditioner top level: pipeline, offsets and handshakes
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------
//  input    | in_valid / in_ready   | in_item   (op, sample, button_level)
//  output   | out_valid / out_ready | out_item  (position, updated, button_event)
//  config   | cfg_we                | cfg_index, cfg_data (x trim, y trim)
//
//  one transaction per cycle unless the output stalls
//  the accumulator update in the first stage is the only per-axis loop
//  the scale multiplier sits in the second stage, the output register in the third
//  reset clears offsets, sums, counts, positions and the button state at once
//  a stalled output holds the pipeline; input is taken while any stage can drain
module joystick_axis_position_conditioner import japc_pkg::*; #(
    parameter int SAMPLES_PER_AVERAGE = DEF_SAMPLES_PER_AVERAGE,
    parameter int POSITION_SPAN       = DEF_POSITION_SPAN,
    parameter int ADC_FULL_SCALE      = DEF_ADC_FULL_SCALE
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_item,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int MEAN_W = $clog2(ADC_FULL_SCALE + 1);

    logic signed [OFFSET_W-1:0] trim_x_reg;
    logic signed [OFFSET_W-1:0] trim_y_reg;

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    in_item_t                   s1_item_reg;

    logic                       s2_valid_reg;
    logic                       s2_valid_next;
    logic [OP_W-1:0]            s2_op_reg;
    logic                       s2_done_reg;
    logic [MEAN_W-1:0]          s2_mean_reg;
    logic [EVENT_W-1:0]         s2_event_reg;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    out_item_t                  out_item_reg;

    logic                       load2;
    logic                       load3;
    logic                       s1_move;
    logic                       s2_move;
    logic                       step_x;
    logic                       step_y;
    logic                       step_btn;
    logic                       done_x;
    logic                       done_y;
    logic [MEAN_W-1:0]          mean_x;
    logic [MEAN_W-1:0]          mean_y;
    logic [EVENT_W-1:0]         btn_event;
    logic                       s1_done;
    logic [MEAN_W-1:0]          s1_mean;
    logic [EVENT_W-1:0]         s1_event;
    logic signed [POSITION_W-1:0] s2_position;

    assign load3    = !out_valid_reg || out_ready;
    assign load2    = !s2_valid_reg || load3;
    assign in_ready = !s1_valid_reg || load2;
    assign s1_move  = s1_valid_reg && load2;
    assign s2_move  = s2_valid_reg && load3;

    assign step_x   = s1_move && (s1_item_reg.op == OP_X);
    assign step_y   = s1_move && (s1_item_reg.op == OP_Y);
    assign step_btn = s1_move && (s1_item_reg.op == OP_BUTTON);

    japc_accum #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
        .POSITION_SPAN       (POSITION_SPAN),
        .ADC_FULL_SCALE      (ADC_FULL_SCALE)
    ) u_accum_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step_x),
        .sample (s1_item_reg.sample),
        .offset (trim_x_reg),
        .done   (done_x),
        .mean   (mean_x)
    );

    japc_accum #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
        .POSITION_SPAN       (POSITION_SPAN),
        .ADC_FULL_SCALE      (ADC_FULL_SCALE)
    ) u_accum_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step_y),
        .sample (s1_item_reg.sample),
        .offset (trim_y_reg),
        .done   (done_y),
        .mean   (mean_y)
    );

    japc_button u_button (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step_btn),
        .level        (s1_item_reg.button_level),
        .button_event (btn_event)
    );

    always_comb
    begin
        s1_done  = 1'b0;
        s1_mean  = mean_x;
        s1_event = EVT_NONE;
        unique case (s1_item_reg.op)
            OP_X:
            begin
                s1_done = done_x;
                s1_mean = mean_x;
            end
            OP_Y:
            begin
                s1_done = done_y;
                s1_mean = mean_y;
            end
            OP_BUTTON:
            begin
                s1_event = btn_event;
            end
            default:
            begin
                s1_done = 1'b0;
            end
        endcase
    end

    japc_scale #(
        .POSITION_SPAN  (POSITION_SPAN),
        .ADC_FULL_SCALE (ADC_FULL_SCALE)
    ) u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (s2_move),
        .op       (s2_op_reg),
        .done     (s2_done_reg),
        .mean     (s2_mean_reg),
        .position (s2_position)
    );

    assign s1_valid_next  = in_ready ? in_valid : s1_valid_reg;
    assign s2_valid_next  = load2 ? s1_valid_reg : s2_valid_reg;
    assign out_valid_next = load3 ? s2_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trim_x_reg <= '0;
            trim_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TRIM_X: trim_x_reg <= signed'(cfg_data[OFFSET_W-1:0]);
                CFG_TRIM_Y: trim_y_reg <= signed'(cfg_data[OFFSET_W-1:0]);
                default:    trim_x_reg <= trim_x_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_move)
        begin
            s2_op_reg    <= s1_item_reg.op;
            s2_done_reg  <= s1_done;
            s2_mean_reg  <= s1_mean;
            s2_event_reg <= s1_event;
        end
        if (s2_move)
        begin
            out_item_reg.position     <= s2_position;
            out_item_reg.updated      <= s2_done_reg;
            out_item_reg.button_event <= s2_event_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s1_valid_reg)
        else $error("accepted transaction lost at the input register");

    a_done_axis_only: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_done_reg) |-> (s2_op_reg == OP_X || s2_op_reg == OP_Y))
        else $error("average completion flagged on a non-axis transaction");

    a_button_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.button_event != EVT_NONE)
            |-> (!out_item_reg.updated && out_item_reg.position == '0))
        else $error("button result carries axis data");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && load3) |=> out_valid_reg)
        else $error("middle stage transaction dropped");

endmodule

@@ rtl/japc_accum.sv @@
// per-axis sample accumulator with bias, clamp and division to the mean
module japc_accum import japc_pkg::*; #(
    parameter int SAMPLES_PER_AVERAGE = DEF_SAMPLES_PER_AVERAGE,
    parameter int POSITION_SPAN       = DEF_POSITION_SPAN,
    parameter int ADC_FULL_SCALE      = DEF_ADC_FULL_SCALE,
    localparam int MEAN_W             = $clog2(ADC_FULL_SCALE + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [SAMPLE_W-1:0]        sample,
    input  logic signed [OFFSET_W-1:0] offset,
    output logic                       done,
    output logic [MEAN_W-1:0]          mean
);

    localparam int CNT_W    = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;
    localparam int SUM_W    = VAL_W + $clog2(SAMPLES_PER_AVERAGE);
    localparam int TOP      = ADC_FULL_SCALE * SAMPLES_PER_AVERAGE;
    localparam int BIAS     = SAMPLES_PER_AVERAGE * (ADC_FULL_SCALE / POSITION_SPAN) / 2;
    localparam int MID_LOW  = ADC_FULL_SCALE / 4;
    localparam int MID_HIGH = (ADC_FULL_SCALE * 3) / 4;
    localparam int FS_W     = $clog2(ADC_FULL_SCALE + 1);
    localparam int CMP_W    = (FS_W > SAMPLE_W) ? FS_W : SAMPLE_W;
    localparam int BIG_W    = $clog2(TOP + BIAS + 1) + 1;
    localparam int WORK_W   = ((SUM_W > BIG_W) ? SUM_W : BIG_W) + 1;
    localparam int CL_W     = $clog2(TOP + 1);
    localparam int K1       = $clog2(longint'(TOP) * SAMPLES_PER_AVERAGE) + 1;
    localparam longint unsigned M1 =
        ((64'd1 << K1) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE;
    localparam int M1_W     = $clog2(M1 + 1);
    localparam int PROD_W   = CL_W + M1_W;

    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [CMP_W-1:0]         sample_ext;
    logic                     mid;
    logic signed [VAL_W-1:0]  sample_s;
    logic signed [VAL_W-1:0]  offset_s;
    logic signed [VAL_W-1:0]  val;
    logic signed [SUM_W-1:0]  acc;
    logic signed [WORK_W-1:0] biased;
    logic [CL_W-1:0]          clamped;
    logic [PROD_W-1:0]        prod;

    assign sample_ext = CMP_W'(sample);
    assign mid        = (sample_ext > CMP_W'(MID_LOW)) && (sample_ext < CMP_W'(MID_HIGH));
    assign sample_s   = signed'({{(VAL_W - SAMPLE_W){1'b0}}, sample});
    assign offset_s   = {{(VAL_W - OFFSET_W){offset[OFFSET_W-1]}}, offset};
    assign val        = mid ? (sample_s + offset_s) : sample_s;
    assign acc        = sum_reg + SUM_W'(val);
    assign biased     = WORK_W'(acc) + WORK_W'(BIAS);
    assign done       = (int'(count_reg) == (SAMPLES_PER_AVERAGE - 1));

    always_comb
    begin
        priority if (biased > WORK_W'(TOP))
        begin
            clamped = CL_W'(TOP);
        end
        else if (biased[WORK_W-1])
        begin
            clamped = '0;
        end
        else
        begin
            clamped = biased[CL_W-1:0];
        end
    end

    // exact division by the sample count through a reciprocal
    assign prod = PROD_W'(clamped) * PROD_W'(M1);
    assign mean = prod[K1 +: MEAN_W];

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (step)
        begin
            if (done)
            begin
                sum_next   = '0;
                count_next = '0;
            end
            else
            begin
                sum_next   = acc;
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) < SAMPLES_PER_AVERAGE)
        else $error("sample count out of range");

    a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (step && done) |=> (sum_reg == '0 && count_reg == '0))
        else $error("accumulator not cleared after a completed average");

endmodule

@@ rtl/japc_button.sv @@
// button level edge detector
module japc_button import japc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               level,
    output logic [EVENT_W-1:0] button_event
);

    logic held_reg;
    logic held_next;

    always_comb
    begin
        held_next    = held_reg;
        button_event = EVT_NONE;
        if (level && !held_reg)
        begin
            held_next    = 1'b1;
            button_event = EVT_PRESS;
        end
        else if (!level && held_reg)
        begin
            held_next    = 1'b0;
            button_event = EVT_RELEASE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
        end
        else if (step)
        begin
            held_reg <= held_next;
        end
    end

endmodule

@@ rtl/japc_scale.sv @@
// mean to position scaling and the held axis positions
module japc_scale import japc_pkg::*; #(
    parameter int POSITION_SPAN  = DEF_POSITION_SPAN,
    parameter int ADC_FULL_SCALE = DEF_ADC_FULL_SCALE,
    localparam int MEAN_W        = $clog2(ADC_FULL_SCALE + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic [OP_W-1:0]              op,
    input  logic                         done,
    input  logic [MEAN_W-1:0]            mean,
    output logic signed [POSITION_W-1:0] position
);

    localparam int K2 = $clog2(longint'(ADC_FULL_SCALE) * ADC_FULL_SCALE) + 1;
    localparam longint unsigned M2 =
        ((longint'(POSITION_SPAN) << K2) + ADC_FULL_SCALE - 1) / ADC_FULL_SCALE;
    localparam int M2_W   = $clog2(M2 + 1);
    localparam int PROD_W = MEAN_W + M2_W;
    localparam int SC_W   = $clog2(POSITION_SPAN + 1);
    localparam int HALF   = POSITION_SPAN / 2;
    localparam int PW     = ((SC_W + 2) > POSITION_W) ? (SC_W + 2) : POSITION_W;

    logic signed [POSITION_W-1:0] pos_x_reg;
    logic signed [POSITION_W-1:0] pos_y_reg;
    logic [PROD_W-1:0]            prod;
    logic [SC_W-1:0]              scaled;
    logic [PW-1:0]                scaled_ext;
    logic [PW-1:0]                pos_x_new;
    logic [PW-1:0]                pos_y_new;

    // truncating scale by span over full scale through a reciprocal
    assign prod       = PROD_W'(mean) * PROD_W'(M2);
    assign scaled     = prod[K2 +: SC_W];
    assign scaled_ext = PW'(scaled);
    assign pos_x_new  = scaled_ext - PW'(HALF);
    assign pos_y_new  = PW'(HALF) - scaled_ext;

    always_comb
    begin
        unique case (op)
            OP_X:    position = done ? signed'(pos_x_new[POSITION_W-1:0]) : pos_x_reg;
            OP_Y:    position = done ? signed'(pos_y_new[POSITION_W-1:0]) : pos_y_reg;
            default: position = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
        end
        else if (load && done)
        begin
            if (op == OP_X)
            begin
                pos_x_reg <= signed'(pos_x_new[POSITION_W-1:0]);
            end
            if (op == OP_Y)
            begin
                pos_y_reg <= signed'(pos_y_new[POSITION_W-1:0]);
            end
        end
    end

endmodule
